// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication under reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant under reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: src/lsms_pkg.sv
// ----------------------------------------------------------------------------
// lsms_pkg
// Types and constants for the LCD scanline mode sequencer.
// ----------------------------------------------------------------------------
package lsms_pkg;

    // Field widths fixed by the interface
    localparam int LINE_W      = 8;
    localparam int WAIT_W      = 7;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 3;

    // Default timing
    localparam int DEF_VISIBLE_LINES = 144;
    localparam int DEF_TOTAL_LINES   = 154;
    localparam int DEF_SCAN_TICKS    = 20;
    localparam int DEF_RENDER_TICKS  = 43;
    localparam int DEF_HBLANK_TICKS  = 51;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_RENDER = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINE_COMPARE  = 3'd0,
        REG_COIN_IRQ_EN   = 3'd1,
        REG_SCAN_IRQ_EN   = 3'd2,
        REG_VBLANK_IRQ_EN = 3'd3,
        REG_HBLANK_IRQ_EN = 3'd4
    } cfg_reg_t;

endpackage

// File: src/lsms_tick_if.sv
// ----------------------------------------------------------------------------
// lsms_tick_if
// Valid/ready channel carrying one tick word.
// ----------------------------------------------------------------------------
interface lsms_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

// File: src/lsms_status_if.sv
// ----------------------------------------------------------------------------
// lsms_status_if
// Valid/ready channel carrying one display status word.
// ----------------------------------------------------------------------------
interface lsms_status_if
    import lsms_pkg::*;
;
    logic                valid;
    logic                ready;
    mode_t               mode;
    logic [LINE_W-1:0]   line;
    logic                coincidence;
    logic                stat_irq;
    logic                oam_locked;
    logic                vram_locked;
    logic                scan_start;
    logic                render_start;

    modport source (
        output valid, output mode, output line, output coincidence, output stat_irq,
        output oam_locked, output vram_locked, output scan_start, output render_start,
        input  ready
    );
    modport sink (
        input  valid, input mode, input line, input coincidence, input stat_irq,
        input  oam_locked, input vram_locked, input scan_start, input render_start,
        output ready
    );
endinterface

// File: src/lcd_scanline_mode_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_scanline_mode_sequencer
// Display mode/line timing: OAM scan, render, hblank, vblank lines.
// ----------------------------------------------------------------------------
// Every word on ticks is one machine cycle of display time. A set tick steps
// the sequencer: it counts down the phase wait, pulses scan_start or
// render_start when a scan or render phase begins, switches mode when a wait
// runs out, bumps the line after hblank and each vblank line, and updates the
// coincidence flag against line_compare on every line bump. stat_irq pulses
// when any enabled source fires in that tick (coincidence, scan entry, vblank
// entry, hblank entry; OR of all). A clear tick returns the current state with
// no pulses. Each accepted tick yields exactly one status word, registered and
// valid in the cycle after acceptance. Throughput is one tick per clock: the state
// update is a single decrement/compare pass between the state registers and
// the status output register, and ticks is only held off while the status
// register is full and not being taken. Configuration writes land on the
// edge where cfg_we is high; indexes past the last register are ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_scanline_mode_sequencer
    import lsms_pkg::*;
#(
    parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
    parameter int TOTAL_LINES   = DEF_TOTAL_LINES,
    parameter int SCAN_TICKS    = DEF_SCAN_TICKS,
    parameter int RENDER_TICKS  = DEF_RENDER_TICKS,
    parameter int HBLANK_TICKS  = DEF_HBLANK_TICKS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    lsms_tick_if.sink              ticks,
    lsms_status_if.source          status
);

    // Vblank line wait: a full line's worth of ticks, saturated to the counter
    localparam int WAIT_MAX   = (1 << WAIT_W) - 1;
    localparam int VB_SUM     = SCAN_TICKS + RENDER_TICKS + HBLANK_TICKS;
    localparam int VB_WAIT    = (VB_SUM > WAIT_MAX) ? WAIT_MAX : VB_SUM;

    localparam logic [WAIT_W-1:0] SCAN_WAIT   = WAIT_W'(SCAN_TICKS);
    localparam logic [WAIT_W-1:0] RENDER_WAIT = WAIT_W'(RENDER_TICKS);
    localparam logic [WAIT_W-1:0] HBLANK_WAIT = WAIT_W'(HBLANK_TICKS);
    localparam logic [WAIT_W-1:0] VBLANK_WAIT = WAIT_W'(VB_WAIT);
    localparam logic [LINE_W-1:0] LAST_VIS    = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W:0]   LINE_WRAP   = (LINE_W+1)'(TOTAL_LINES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LINE_W-1:0] line_compare_reg;
    logic              coin_irq_en_reg;
    logic              scan_irq_en_reg;
    logic              vblank_irq_en_reg;
    logic              hblank_irq_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_compare_reg  <= '0;
            coin_irq_en_reg   <= 1'b0;
            scan_irq_en_reg   <= 1'b0;
            vblank_irq_en_reg <= 1'b0;
            hblank_irq_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINE_COMPARE:  line_compare_reg  <= cfg_data[LINE_W-1:0];
                REG_COIN_IRQ_EN:   coin_irq_en_reg   <= cfg_data[0];
                REG_SCAN_IRQ_EN:   scan_irq_en_reg   <= cfg_data[0];
                REG_VBLANK_IRQ_EN: vblank_irq_en_reg <= cfg_data[0];
                REG_HBLANK_IRQ_EN: hblank_irq_en_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    mode_t             mode_reg,   mode_next;
    logic [WAIT_W-1:0] wait_reg,   wait_next;
    logic [LINE_W-1:0] line_reg,   line_next;
    logic              coin_reg,   coin_next;
    logic              oam_lock_reg,  oam_lock_next;
    logic              vram_lock_reg, vram_lock_next;

    // Status output register
    logic              out_valid_reg;
    mode_t             out_mode_reg;
    logic [LINE_W-1:0] out_line_reg;
    logic              out_coin_reg;
    logic              out_irq_reg,    irq_next;
    logic              out_oam_reg;
    logic              out_vram_reg;
    logic              out_scan_reg,   scan_next;
    logic              out_render_reg, render_next;

    logic              accept;
    logic              do_switch;
    logic [LINE_W:0]   line_inc;
    logic [LINE_W-1:0] line_step;
    logic              coin_hit;

    // Take a tick whenever the status register is free or draining this cycle
    assign ticks.ready = !out_valid_reg || status.ready;
    assign accept      = ticks.valid && ticks.ready;

    // Line bump with wrap at the frame end
    assign line_inc  = {1'b0, line_reg} + (LINE_W+1)'(1);
    assign line_step = (line_inc == LINE_WRAP) ? '0 : line_inc[LINE_W-1:0];
    assign coin_hit  = (line_step == line_compare_reg);

    always_comb
    begin
        mode_next      = mode_reg;
        wait_next      = wait_reg;
        line_next      = line_reg;
        coin_next      = coin_reg;
        oam_lock_next  = oam_lock_reg;
        vram_lock_next = vram_lock_reg;
        irq_next       = 1'b0;
        scan_next      = 1'b0;
        render_next    = 1'b0;
        do_switch      = 1'b0;

        if (accept && ticks.tick)
        begin
            if (wait_reg != '0)
            begin
                wait_next = wait_reg - WAIT_W'(1);
                do_switch = (wait_reg == WAIT_W'(1));
            end
            else if (mode_reg == MODE_SCAN)
            begin
                scan_next = 1'b1;
                wait_next = SCAN_WAIT;
            end
            else if (mode_reg == MODE_RENDER)
            begin
                render_next = 1'b1;
                wait_next   = RENDER_WAIT;
            end
            else
            begin
                // zero wait in a blank phase: switch straight away
                do_switch = 1'b1;
            end
        end

        if (do_switch)
        begin
            unique case (mode_reg)
                MODE_HBLANK:
                begin
                    line_next = line_step;
                    coin_next = coin_hit;
                    irq_next  = coin_hit && coin_irq_en_reg;
                    if (line_step == LAST_VIS)
                    begin
                        mode_next = MODE_VBLANK;
                        wait_next = VBLANK_WAIT;
                        irq_next  = irq_next || vblank_irq_en_reg;
                    end
                    else
                    begin
                        mode_next     = MODE_SCAN;
                        oam_lock_next = 1'b1;
                        irq_next      = irq_next || scan_irq_en_reg;
                    end
                end
                MODE_VBLANK:
                begin
                    line_next = line_step;
                    coin_next = coin_hit;
                    irq_next  = coin_hit && coin_irq_en_reg;
                    if (line_step == '0)
                    begin
                        mode_next     = MODE_SCAN;
                        oam_lock_next = 1'b1;
                        irq_next      = irq_next || scan_irq_en_reg;
                    end
                    else
                    begin
                        wait_next = VBLANK_WAIT;
                    end
                end
                MODE_SCAN:
                begin
                    mode_next      = MODE_RENDER;
                    vram_lock_next = 1'b1;
                end
                MODE_RENDER:
                begin
                    mode_next      = MODE_HBLANK;
                    oam_lock_next  = 1'b0;
                    vram_lock_next = 1'b0;
                    wait_next      = HBLANK_WAIT;
                    irq_next       = hblank_irq_en_reg;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SCAN;
            wait_reg      <= '0;
            line_reg      <= '0;
            coin_reg      <= 1'b0;
            oam_lock_reg  <= 1'b1;
            vram_lock_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            wait_reg      <= wait_next;
            line_reg      <= line_next;
            coin_reg      <= coin_next;
            oam_lock_reg  <= oam_lock_next;
            vram_lock_reg <= vram_lock_next;
        end
    end

    // Status word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Status word payload: post-tick state plus pulses
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_mode_reg   <= mode_next;
            out_line_reg   <= line_next;
            out_coin_reg   <= coin_next;
            out_irq_reg    <= irq_next;
            out_oam_reg    <= oam_lock_next;
            out_vram_reg   <= vram_lock_next;
            out_scan_reg   <= scan_next;
            out_render_reg <= render_next;
        end
    end

    assign status.valid        = out_valid_reg;
    assign status.mode         = out_mode_reg;
    assign status.line         = out_line_reg;
    assign status.coincidence  = out_coin_reg;
    assign status.stat_irq     = out_irq_reg;
    assign status.oam_locked   = out_oam_reg;
    assign status.vram_locked  = out_vram_reg;
    assign status.scan_start   = out_scan_reg;
    assign status.render_start = out_render_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_gives_word, clk, rst_n, accept, out_valid_reg, "accepted tick gave no status word")
    `ASSERT_IMPLIES(a_scan_locks, clk, rst_n, (mode_reg == MODE_SCAN) || (mode_reg == MODE_RENDER), oam_lock_reg, "OAM unlocked during scan or render")
    `ASSERT_IMPLIES(a_blank_unlocks, clk, rst_n, (mode_reg == MODE_HBLANK) || (mode_reg == MODE_VBLANK), !oam_lock_reg && !vram_lock_reg, "memory locked during blanking")
    `ASSERT_ALWAYS(a_line_range, clk, rst_n, {1'b0, line_reg} < LINE_WRAP, "line counter past frame end")
    `ASSERT_IMPLIES(a_scan_pulse_mode, clk, rst_n, out_valid_reg && out_scan_reg, out_mode_reg == MODE_SCAN, "scan_start outside scan mode")

endmodule

// File: test/lcd_scanline_mode_sequencer_tb.sv
// ----------------------------------------------------------------------------
// lcd_scanline_mode_sequencer_tb
// Self-checking bench for the scanline mode sequencer: ticks are driven over a
// valid/ready channel, an in-bench timing model predicts every status word and
// a monitor compares the words field by field. Registers are reprogrammed
// between phases while the block is idle, over the first lines of a frame.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_sequencer_tb;
    import lsms_pkg::*;

    // Vblank lines last a whole visible line, clipped to the 7-bit counter
    localparam int VBLANK_LINE_TICKS =
        (DEF_SCAN_TICKS + DEF_RENDER_TICKS + DEF_HBLANK_TICKS > 127) ? 127 :
        (DEF_SCAN_TICKS + DEF_RENDER_TICKS + DEF_HBLANK_TICKS);
    // Index past the last register: the block must ignore writes to it
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 3'd7;
    localparam int NUM_PHASES  = 13;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        mode_t             mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic              stat_irq;
        logic              oam_locked;
        logic              vram_locked;
        logic              scan_start;
        logic              render_start;
    } status_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    lsms_tick_if   tick_ch ();
    lsms_status_if status_ch ();

    lcd_scanline_mode_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ticks     (tick_ch),
        .status    (status_ch)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Display timing model: own copy of state and registers
    // ------------------------------------------------------------------------
    mode_t             cur_mode;
    logic [WAIT_W-1:0] phase_wait;
    logic [LINE_W-1:0] cur_line;
    logic              coin_flag;
    logic              oam_lock_q;
    logic              vram_lock_q;

    logic [LINE_W-1:0] cmp_line;
    logic              coin_en;
    logic              scan_en;
    logic              vblank_en;
    logic              hblank_en;

    logic         tick_queue [$];   // ticks waiting for the driver
    status_word_t status_due [$];   // predicted words, oldest first

    int src_gap        = 0;
    int sink_gap       = 0;
    int idle_odds      = 0;         // 0: no idling, else 1-in-N chance of a burst
    int ticks_offered  = 0;
    int ticks_taken    = 0;
    int stall_cycles   = 0;
    int mismatch_count = 0;

    function automatic void reset_display();
        cur_mode    = MODE_SCAN;
        phase_wait  = '0;
        cur_line    = '0;
        coin_flag   = 1'b0;
        oam_lock_q  = 1'b1;
        vram_lock_q = 1'b0;
        cmp_line    = '0;
        coin_en     = 1'b0;
        scan_en     = 1'b0;
        vblank_en   = 1'b0;
        hblank_en   = 1'b0;
    endfunction

    // Line bump: wraps at the frame end and refreshes the coincidence flag
    function automatic logic bump_line();
        int nxt;
        nxt = (int'(cur_line) + 1) % DEF_TOTAL_LINES;
        cur_line  = nxt[LINE_W-1:0];
        coin_flag = (cur_line == cmp_line);
        return coin_flag & coin_en;
    endfunction

    function automatic logic open_scan();
        oam_lock_q = 1'b1;
        cur_mode   = MODE_SCAN;
        return scan_en;
    endfunction

    // Mode switch at the end of a phase wait; returns the raised irq sources
    function automatic logic next_phase();
        logic irq;
        irq = 1'b0;
        case (cur_mode)
            MODE_HBLANK:
            begin
                irq = bump_line();
                if (cur_line == DEF_VISIBLE_LINES)
                begin
                    cur_mode   = MODE_VBLANK;
                    phase_wait = WAIT_W'(VBLANK_LINE_TICKS);
                    irq        = irq | vblank_en;
                end
                else
                begin
                    irq = irq | open_scan();
                end
            end
            MODE_VBLANK:
            begin
                irq = bump_line();
                if (cur_line == 0)
                    irq = irq | open_scan();
                else
                    phase_wait = WAIT_W'(VBLANK_LINE_TICKS);
            end
            MODE_SCAN:
            begin
                vram_lock_q = 1'b1;
                cur_mode    = MODE_RENDER;
            end
            default:
            begin
                oam_lock_q  = 1'b0;
                vram_lock_q = 1'b0;
                cur_mode    = MODE_HBLANK;
                phase_wait  = WAIT_W'(DEF_HBLANK_TICKS);
                irq         = irq | hblank_en;
            end
        endcase
        return irq;
    endfunction

    // One accepted tick word -> the status word it should produce
    function automatic status_word_t step_display(logic tk);
        status_word_t w;
        logic         irq;
        logic         scan;
        logic         render;
        irq    = 1'b0;
        scan   = 1'b0;
        render = 1'b0;
        if (tk)
        begin
            if (phase_wait != 0)
            begin
                phase_wait = phase_wait - 1'b1;
                if (phase_wait == 0)
                    irq = next_phase();
            end
            else if (cur_mode == MODE_SCAN)
            begin
                scan       = 1'b1;
                phase_wait = WAIT_W'(DEF_SCAN_TICKS);
            end
            else if (cur_mode == MODE_RENDER)
            begin
                render     = 1'b1;
                phase_wait = WAIT_W'(DEF_RENDER_TICKS);
            end
            else
            begin
                // zero wait in a blank mode: switch straight away
                irq = next_phase();
            end
        end
        // a clear tick just reports the state with no pulses
        w.mode         = cur_mode;
        w.line         = cur_line;
        w.coincidence  = coin_flag;
        w.stat_irq     = irq;
        w.oam_locked   = oam_lock_q;
        w.vram_locked  = vram_lock_q;
        w.scan_start   = scan;
        w.render_start = render;
        return w;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("status %s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tick driver: presents queued words at the falling edge, holds a word
    // until the monitor has seen it taken, idles in random bursts
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : tick_driver
        logic nxt_valid;
        logic nxt_tick;
        nxt_valid = tick_ch.valid;
        nxt_tick  = tick_ch.tick;
        if (!rst_n)
        begin
            nxt_valid = 1'b0;
            nxt_tick  = 1'b0;
        end
        else if (!tick_ch.valid || ticks_taken == ticks_offered)
        begin
            nxt_valid = 1'b0;
            if (src_gap != 0)
                src_gap = src_gap - 1;
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                src_gap = $urandom_range(0, 8);   // gap counter set to 0..8
            else if (tick_queue.size() != 0)
            begin
                nxt_valid = 1'b1;
                nxt_tick  = tick_queue.pop_front();
                ticks_offered++;
            end
        end
        tick_ch.valid <= nxt_valid;
        tick_ch.tick  <= nxt_tick;
    end

    // Status sink: ready, with random stall bursts (gap counter set to 0..8)
    always @(negedge clk)
    begin : status_sink
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (!rst_n)
            nxt_ready = 1'b0;
        else if (sink_gap != 0)
        begin
            sink_gap  = sink_gap - 1;
            nxt_ready = 1'b0;
        end
        else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            sink_gap  = $urandom_range(0, 8);
            nxt_ready = 1'b0;
        end
        status_ch.ready <= nxt_ready;
    end

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge, check a taken status word against the
    // oldest prediction, then predict for a tick taken at the same edge.
    // Status is registered, so a word never belongs to a same-edge tick.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : status_monitor
        status_word_t want;
        logic         moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (status_ch.valid && status_ch.ready)
            begin
                moved = 1'b1;
                if (status_due.size() == 0)
                begin
                    $error("status word arrived with none expected");
                    mismatch_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("mode", 8'(want.mode), 8'(status_ch.mode));
                    check_field("line", want.line, status_ch.line);
                    check_field("coincidence", 8'(want.coincidence),
                                8'(status_ch.coincidence));
                    check_field("stat_irq", 8'(want.stat_irq), 8'(status_ch.stat_irq));
                    check_field("oam_locked", 8'(want.oam_locked),
                                8'(status_ch.oam_locked));
                    check_field("vram_locked", 8'(want.vram_locked),
                                8'(status_ch.vram_locked));
                    check_field("scan_start", 8'(want.scan_start),
                                8'(status_ch.scan_start));
                    check_field("render_start", 8'(want.render_start),
                                8'(status_ch.render_start));
                end
            end
            if (tick_ch.valid && tick_ch.ready)
            begin
                moved = 1'b1;
                status_due.push_back(step_display(tick_ch.tick));
                ticks_taken++;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    // Watchdog: too long without any word moving on either channel
    initial
    begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Register write: one cycle with cfg_we high, model follows after the edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_LINE_COMPARE:  cmp_line  = val;
            REG_COIN_IRQ_EN:   coin_en   = val[0];
            REG_SCAN_IRQ_EN:   scan_en   = val[0];
            REG_VBLANK_IRQ_EN: vblank_en = val[0];
            REG_HBLANK_IRQ_EN: hblank_en = val[0];
            default: ;
        endcase
    endtask

    // Enable bits go out with random upper bits; only bit 0 should count
    function automatic logic [CFG_DATA_W-1:0] enable_word(logic en);
        logic [CFG_DATA_W-1:0] w;
        w    = CFG_DATA_W'($urandom);
        w[0] = en;
        return w;
    endfunction

    // Wait until every queued tick is taken and every status word is back.
    // Checked at the falling edge, after all rising-edge bookkeeping.
    task automatic wait_drained();
        @(negedge clk);
        while (tick_queue.size() != 0 || ticks_taken != ticks_offered ||
               status_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                    n_ticks;
        logic [CFG_DATA_W-1:0] cmp_val;
        reset_display();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: clear ticks straight out of reset and in between set
        // ticks, through the first scan start and part of its scan wait, with all
        // registers still at reset.
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        for (int i = 0; i < 22; i++)
            tick_queue.push_back((i % 7) != 3);
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Idling pattern per phase: none, heavy, light; last phase clean
            case (phase % 3)
                0:       idle_odds = 0;
                1:       idle_odds = 4;
                default: idle_odds = 16;
            endcase
            if (phase == NUM_PHASES - 1)
                idle_odds = 0;

            // Compare value: extremes, the last line, the vblank start, the line we sit on
            // (flag must not move on the write), a line just ahead, random
            case (phase % 7)
                0:       cmp_val = 8'd0;
                1:       cmp_val = 8'd255;
                2:       cmp_val = CFG_DATA_W'(DEF_TOTAL_LINES - 1);
                3:       cmp_val = CFG_DATA_W'(DEF_VISIBLE_LINES);
                4:       cmp_val = cur_line;
                5:       cmp_val = CFG_DATA_W'((int'(cur_line) + $urandom_range(1, 25))
                                               % DEF_TOTAL_LINES);
                default: cmp_val = CFG_DATA_W'($urandom_range(0, 255));
            endcase
            write_reg(REG_LINE_COMPARE, cmp_val);

            // Enables: all off, all on, then random mixes
            if (phase == 0 || phase == 1)
            begin
                write_reg(REG_COIN_IRQ_EN, enable_word(phase == 1));
                write_reg(REG_SCAN_IRQ_EN, enable_word(phase == 1));
                write_reg(REG_VBLANK_IRQ_EN, enable_word(phase == 1));
                write_reg(REG_HBLANK_IRQ_EN, enable_word(phase == 1));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    write_reg(REG_COIN_IRQ_EN, enable_word(1'($urandom_range(0, 1))));
                if ($urandom_range(0, 1))
                    write_reg(REG_SCAN_IRQ_EN, enable_word(1'($urandom_range(0, 1))));
                if ($urandom_range(0, 1))
                    write_reg(REG_VBLANK_IRQ_EN, enable_word(1'($urandom_range(0, 1))));
                if ($urandom_range(0, 1))
                    write_reg(REG_HBLANK_IRQ_EN, enable_word(1'($urandom_range(0, 1))));
            end
            if (phase % 4 == 2)
                write_reg(CFG_INDEX_SPARE, CFG_DATA_W'($urandom));

            // Under a line's worth of ticks per phase; the run crosses
            // scan, render, hblank and a dozen or so line bumps
            n_ticks = $urandom_range(80, 110);
            for (int i = 0; i < n_ticks; i++)
                tick_queue.push_back($urandom_range(0, 31) != 0);
            // sender holds off until every status word is back
            wait_drained();
        end

        // Tail: one more stretch with no idling on either side
        idle_odds = 0;
        for (int i = 0; i < 400; i++)
            tick_queue.push_back($urandom_range(0, 31) != 0);
        wait_drained();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && status_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
